// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers used by the RTL of the load meter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, switched off while reset is held
`define ICLM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds across reset
`define ICLM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hw/rtl/iclm_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package iclm_pkg;

  // Widths of the sample path and of the running sum
  localparam int SAMPLE_W = 16;
  localparam int SUM_W    = 40;
  // Dividend widths: rounded average (sum plus half count) and mapping
  localparam int AVGN_W   = SUM_W + 1;
  localparam int MAPN_W   = 2 * SAMPLE_W + 1;

  // Configuration register indexes
  localparam logic [1:0] REG_EXP_COUNT  = 2'd0;
  localparam logic [1:0] REG_FULL_SCALE = 2'd1;

  // Reset values
  localparam logic [SAMPLE_W-1:0] EXP_COUNT_RST  = 16'hFFFF;
  localparam logic [SAMPLE_W-1:0] FULL_SCALE_RST = 16'd1250;
  localparam logic [SAMPLE_W-1:0] DELTA_MIN_RST  = 16'hFFFF;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [SUM_W-1:0]    sum_t;

  // Result payload, first field in the highest bits
  typedef struct packed {
    sample_t max_load;
    sample_t avg_load;
    sample_t min_load;
  } result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/idle_counter_load_meter_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Processor load meter fed from a free-running 16-bit idle counter, one
// instance per core. A tick transfer (in_tuser low) carries the counter
// reading; the wrapped delta from the previous reading updates the minimum,
// maximum, saturating sum and saturating count, so ticks are taken back to
// back when idle. A query transfer (in_tuser high) computes the rounded
// average delta and maps maximum, average and minimum onto full scale,
// reporting full_scale minus each mapped value as min, avg and max load, then
// clears the statistics. All four divisions run on one shared restoring
// divider that retires one quotient bit per cycle; a query holds in_tready low
// until its result is loaded, after any wait for the previous result to be
// taken. With no tick since the last query the average is zero and out_tuser
// set. The result stays in an output register while new ticks are taken.
// Configuration writes are accepted in every cycle; index 0 is the expected
// full count per tick, index 1 the full scale, other indexes are ignored.
module idle_counter_load_meter_top
  import iclm_pkg::*;
#(
  parameter int COUNT_BITS = 24
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,   // [15:0] counter_reading
  input  wire logic        in_tuser,   // [0] req_type
  // Result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [47:0]      out_tdata,  // [15:0] min_load, [31:16] avg_load, [47:32] max_load
  output logic             out_tuser,  // [0] no_samples
  // Configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  localparam int DIV_W  = (COUNT_BITS > SAMPLE_W) ? COUNT_BITS : SAMPLE_W;
  localparam int STEP_W = $clog2(AVGN_W + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_AVG  = 3'd1;
  localparam logic [2:0] S_AVGW = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_MAP  = 3'd4;
  localparam logic [2:0] S_MAPW = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  localparam logic [1:0] IDX_AVG = 2'd0;
  localparam logic [1:0] IDX_MAX = 2'd1;
  localparam logic [1:0] IDX_MIN = 2'd2;

  // Configuration
  sample_t exp_r, fs_r;
  // Statistics
  sample_t prev_r, min_r, max_r;
  sum_t    sum_r;
  logic [COUNT_BITS-1:0] cnt_r;
  // Sequencer and divider
  logic [2:0]        state_r, state_nxt;
  logic [1:0]        idx_r;
  logic [STEP_W-1:0] step_r;
  logic [AVGN_W-1:0] num_r, num_nxt;
  logic [DIV_W-1:0]  div_r, rem_nxt;
  logic [DIV_W-1:0]  rem_r;
  logic              sat_r, none_r;
  sample_t           avg_r;
  result_t           res_r;
  // Output register
  logic              out_valid_r;
  result_t           out_data_r;
  logic              out_none_r;

  logic    in_xfer, tick, query, out_load, div_last;
  sample_t delta, v_sel, map_val, load_val;
  logic [SUM_W:0]        sum_add;
  logic [DIV_W:0]        rem_sh;
  logic                  rem_ge;
  logic [2*SAMPLE_W-1:0] prod;
  logic [MAPN_W-1:0]     map_num;
  logic [AVGN_W-1:0]     avg_num;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign in_xfer    = in_tvalid && in_tready;
  assign tick       = in_xfer && !in_tuser;
  assign query      = in_xfer && in_tuser;
  assign out_load   = (state_r == S_OUT) && (!out_valid_r || out_tready);
  assign div_last   = (step_r == STEP_W'(1));

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_data_r.max_load, out_data_r.avg_load, out_data_r.min_load};
  assign out_tuser  = out_none_r;

  // Tick datapath: wrapped delta and saturating sum
  assign delta   = in_tdata - prev_r;
  assign sum_add = {1'b0, sum_r} + {{(SUM_W + 1 - SAMPLE_W){1'b0}}, delta};
  // Rounded-average dividend
  assign avg_num = {1'b0, sum_r} + {{(AVGN_W - COUNT_BITS + 1){1'b0}},
                                    cnt_r[COUNT_BITS-1:1]};

  // Restoring divider step: one quotient bit per cycle
  assign rem_sh  = {rem_r, num_r[AVGN_W-1]};
  assign rem_ge  = (rem_sh >= {1'b0, div_r});
  assign rem_nxt = rem_ge ? rem_sh[DIV_W-1:0] - div_r : rem_sh[DIV_W-1:0];
  assign num_nxt = {num_r[AVGN_W-2:0], rem_ge};

  // Mapping dividend: v * full_scale + expected / 2
  always_comb begin
    case (idx_r)
      IDX_AVG: v_sel = avg_r;
      IDX_MAX: v_sel = max_r;
      IDX_MIN: v_sel = min_r;
      default: v_sel = avg_r;
    endcase
  end
  assign prod    = v_sel * fs_r;
  assign map_num = {1'b0, prod} + {{(MAPN_W - SAMPLE_W + 1){1'b0}}, exp_r[SAMPLE_W-1:1]};

  // Below the expected count the rounded quotient never exceeds full scale
  assign map_val  = sat_r ? fs_r : num_r[SAMPLE_W-1:0];
  assign load_val = fs_r - map_val;

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (query) state_nxt = (cnt_r == '0) ? S_MUL : S_AVG;
      S_AVG:  if (div_last) state_nxt = S_AVGW;
      S_AVGW: state_nxt = S_MUL;
      S_MUL:  state_nxt = S_MAP;
      S_MAP:  if (div_last) state_nxt = S_MAPW;
      S_MAPW: state_nxt = (idx_r == IDX_MIN) ? S_OUT : S_MUL;
      S_OUT:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      idx_r   <= IDX_AVG;
    end else begin
      state_r <= state_nxt;
      if (query || state_r == S_OUT) begin
        idx_r <= IDX_AVG;
      end else if (state_r == S_MAPW && idx_r != IDX_MIN) begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r <= EXP_COUNT_RST;
      fs_r  <= FULL_SCALE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_EXP_COUNT:  exp_r <= cfg_data;
        REG_FULL_SCALE: fs_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Statistics: update on tick, clear when the result is loaded
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
      min_r  <= DELTA_MIN_RST;
      max_r  <= '0;
      sum_r  <= '0;
      cnt_r  <= '0;
    end else if (tick) begin
      prev_r <= in_tdata;
      if (delta < min_r) min_r <= delta;
      if (delta > max_r) max_r <= delta;
      sum_r <= sum_add[SUM_W] ? '1 : sum_add[SUM_W-1:0];
      if (cnt_r != '1) cnt_r <= cnt_r + 1'b1;
    end else if (out_load) begin
      min_r <= DELTA_MIN_RST;
      max_r <= '0;
      sum_r <= '0;
      cnt_r <= '0;
    end
  end

  // Divider operands and per-query results
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        num_r  <= avg_num;
        div_r  <= DIV_W'(cnt_r);
        rem_r  <= '0;
        step_r <= STEP_W'(AVGN_W);
        avg_r  <= '0;
        none_r <= (cnt_r == '0);
      end
      S_AVG, S_MAP: begin
        num_r  <= num_nxt;
        rem_r  <= rem_nxt;
        step_r <= step_r - 1'b1;
      end
      S_AVGW: begin
        avg_r <= (|num_r[AVGN_W-1:SAMPLE_W]) ? '1 : num_r[SAMPLE_W-1:0];
      end
      S_MUL: begin
        num_r  <= {map_num, {(AVGN_W - MAPN_W){1'b0}}};
        div_r  <= DIV_W'(exp_r);
        rem_r  <= '0;
        step_r <= STEP_W'(MAPN_W);
        sat_r  <= (exp_r == '0) || (v_sel >= exp_r);
      end
      S_MAPW: begin
        case (idx_r)
          IDX_AVG: res_r.avg_load <= load_val;
          IDX_MAX: res_r.min_load <= load_val;
          IDX_MIN: res_r.max_load <= load_val;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= res_r;
      out_none_r <= none_r;
    end
  end

  // Checks
  `include "assert_macros.svh"

  `ICLM_ASSERT(a_result_from_seq,
    $rose(out_valid_r) |-> $past(state_r == S_OUT),
    "result appeared without a finished query")
  `ICLM_ASSERT(a_stats_cleared,
    out_load |=> (cnt_r == '0 && max_r == '0 && min_r == DELTA_MIN_RST && sum_r == '0),
    "statistics not cleared after a query")
  `ICLM_ASSERT(a_map_in_range,
    (state_r == S_MAPW && !sat_r) |-> (num_r[MAPN_W-1:0] <= {{(MAPN_W - SAMPLE_W){1'b0}}, fs_r}),
    "mapped value exceeds full scale")
  `ICLM_ASSERT(a_count_saturates,
    (tick && cnt_r == '1) |=> (cnt_r == '1),
    "sample count wrapped")
  `ICLM_ASSERT_ALWAYS(a_reset_idle,
    !rst_n |=> (state_r == S_IDLE && !out_valid_r),
    "reset did not return the sequencer to idle")

endmodule

`default_nettype wire
